### rtl/core/cdt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cdt_pkg;

  localparam int unsigned COUNT_W   = 18;
  localparam int unsigned REM_W     = 17;
  localparam int unsigned YEAR_W    = 14;
  localparam int unsigned MONTH_W   = 4;
  localparam int unsigned DAY_W     = 5;
  localparam int unsigned WDAY_W    = 3;
  localparam int unsigned HOUR_W    = 5;
  localparam int unsigned MIN_W     = 6;
  localparam int unsigned SEC_W     = 6;
  localparam int unsigned SOH_W     = 12;  // seconds within the hour
  localparam int unsigned CENT_W    = 8;   // year / 100
  localparam int unsigned SUM_W     = 15;  // weekday sum before reduction
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 14;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic [COUNT_W-1:0] SECS_1DAY = 18'd86400;
  localparam logic [COUNT_W-1:0] SECS_2DAY = 18'd172800;
  localparam logic [COUNT_W-1:0] SECS_3DAY = 18'd259200;

  // Reciprocals for exact floor division over the ranges used here.
  localparam logic [16:0] RECIP_3600 = 17'd74566;  // shift 28, rem below 86400
  localparam logic [16:0] RECIP_60   = 17'd69906;  // shift 22, value below 3600
  localparam logic [12:0] RECIP_100  = 13'd5243;   // shift 19, 14-bit years

  localparam logic [YEAR_W-1:0]  RESET_YEAR  = 14'd2021;
  localparam logic [MONTH_W-1:0] RESET_MONTH = 4'd3;
  localparam logic [DAY_W-1:0]   RESET_DAY   = 5'd8;
  localparam logic [YEAR_W-1:0]  YEAR_LAST   = 14'd9999;
  localparam logic [YEAR_W-1:0]  YEAR_FIRST  = 14'd1;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [WDAY_W-1:0] OFFS_COMMON [12] = '{3'd0, 3'd3, 3'd3, 3'd6, 3'd1, 3'd4,
                                                    3'd6, 3'd2, 3'd5, 3'd0, 3'd3, 3'd5};
  localparam logic [WDAY_W-1:0] OFFS_LEAP   [12] = '{3'd6, 3'd2, 3'd3, 3'd6, 3'd1, 3'd4,
                                                    3'd6, 3'd2, 3'd5, 3'd0, 3'd3, 3'd5};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_YEAR  = 2'd0,
    REG_START_MONTH = 2'd1,
    REG_START_DAY   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic                  en;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  // One classified reading as it leaves the front end.
  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic              passed;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SOH_W-1:0]  soh;
  } time_item_t;

  typedef struct packed {
    logic [REM_W-1:0]   restart_value;
    logic               restart_counter;
    logic [SEC_W-1:0]   second_now;
    logic [MIN_W-1:0]   minute_now;
    logic [HOUR_W-1:0]  hour_now;
    logic               leap_now;
    logic [WDAY_W-1:0]  weekday_now;
    logic [DAY_W-1:0]   day_now;
    logic [MONTH_W-1:0] month_now;
    logic [YEAR_W-1:0]  year_now;
  } result_t;

  function automatic logic [CENT_W-1:0] div100(input logic [YEAR_W-1:0] y);
    logic [26:0] p;
    p = 27'(y) * 27'(RECIP_100);
    return p[26:19];
  endfunction

  // Leap test given the year and its quotient by 100.
  function automatic logic leap_of(input logic [YEAR_W-1:0] y,
                                   input logic [CENT_W-1:0] q);
    logic century;
    century = (YEAR_W'(q) * 14'd100) == y;
    return century ? (q[1:0] == 2'd0) : (y[1:0] == 2'd0);
  endfunction

  function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      MONTH_FEB: len = leap ? 5'd29 : 5'd28;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [WDAY_W-1:0] month_offset(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
    logic [MONTH_W-1:0] idx;
    logic [WDAY_W-1:0]  off;
    idx = m - MONTH_JAN;
    off = '0;
    if (m inside {[MONTH_JAN:MONTH_DEC]}) begin
      off = leap ? OFFS_LEAP[idx] : OFFS_COMMON[idx];
    end
    return off;
  endfunction

  // Eight is one more than seven, so octal digits fold.
  function automatic logic [WDAY_W-1:0] mod7(input logic [SUM_W-1:0] v);
    logic [5:0] s1;
    logic [3:0] s2;
    logic [2:0] s3;
    s1 = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9]) + 6'(v[14:12]);
    s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
    s3 = s2[2:0] + 3'(s2[3]);
    return (s3 == 3'd7) ? 3'd0 : s3;
  endfunction

endpackage

`default_nettype wire

### rtl/core/cdt_front.sv
`timescale 1ns / 1ps
`default_nettype none

module cdt_front (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [cdt_pkg::COUNT_W-1:0] in_count,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output cdt_pkg::time_item_t             out_item
);
  import cdt_pkg::*;

  logic              f1_v, f2_v, f3_v, f4_v;
  logic              f1_rdy, f2_rdy, f3_rdy, f4_rdy;
  logic [REM_W-1:0]  f1_rem, f2_rem, f3_rem;
  logic              f1_passed, f2_passed, f3_passed;
  logic [HOUR_W-1:0] f2_hour, f3_hour;
  logic [SOH_W-1:0]  f3_soh;
  time_item_t        f4_item;

  logic [COUNT_W-1:0] day_sub;
  logic [COUNT_W-1:0] rem_full;
  logic [33:0]        hour_prod;
  logic [REM_W-1:0]   soh_full;
  logic [28:0]        min_prod;

  assign f4_rdy = !f4_v || out_ready;
  assign f3_rdy = !f3_v || f4_rdy;
  assign f2_rdy = !f2_v || f3_rdy;
  assign f1_rdy = !f1_v || f2_rdy;
  assign in_ready = f1_rdy;

  // Counts beyond the range of use still reduce to the remainder of a day.
  always_comb begin
    if (in_count >= SECS_3DAY) begin
      day_sub = SECS_3DAY;
    end else if (in_count >= SECS_2DAY) begin
      day_sub = SECS_2DAY;
    end else if (in_count >= SECS_1DAY) begin
      day_sub = SECS_1DAY;
    end else begin
      day_sub = '0;
    end
    rem_full  = in_count - day_sub;
    hour_prod = 34'(f1_rem) * 34'(RECIP_3600);
    soh_full  = f2_rem - REM_W'(f2_hour) * 17'd3600;
    min_prod  = 29'(f3_soh) * 29'(RECIP_60);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
      f2_v <= 1'b0;
      f3_v <= 1'b0;
      f4_v <= 1'b0;
    end else begin
      if (f1_rdy) f1_v <= in_valid;
      if (f2_rdy) f2_v <= f1_v;
      if (f3_rdy) f3_v <= f2_v;
      if (f4_rdy) f4_v <= f3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (f1_rdy) begin
      f1_rem    <= rem_full[REM_W-1:0];
      f1_passed <= (day_sub != '0);
    end
    if (f2_rdy) begin
      f2_rem    <= f1_rem;
      f2_passed <= f1_passed;
      f2_hour   <= hour_prod[32:28];
    end
    if (f3_rdy) begin
      f3_rem    <= f2_rem;
      f3_passed <= f2_passed;
      f3_hour   <= f2_hour;
      f3_soh    <= soh_full[SOH_W-1:0];
    end
    if (f4_rdy) begin
      f4_item.rem    <= f3_rem;
      f4_item.passed <= f3_passed;
      f4_item.hour   <= f3_hour;
      f4_item.soh    <= f3_soh;
      f4_item.minute <= min_prod[27:22];
    end
  end

  assign out_valid = f4_v;
  assign out_item  = f4_item;

endmodule

`default_nettype wire

### rtl/core/cdt_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module cdt_queue #(
  parameter int unsigned DEPTH = cdt_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push_valid,
  output logic                     push_ready,
  input  wire cdt_pkg::time_item_t push_item,
  output logic                     pop_valid,
  input  wire logic                pop_ready,
  output cdt_pkg::time_item_t      pop_item
);
  import cdt_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  time_item_t       slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push, do_pop;

  assign push_ready = (fill != CNT_FULL);
  assign pop_valid  = (fill != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_item;
  end

endmodule

`default_nettype wire

### rtl/core/cdt_back.sv
`timescale 1ns / 1ps
`default_nettype none

module cdt_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cdt_pkg::cfg_wr_t    cfg,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire cdt_pkg::time_item_t in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output cdt_pkg::result_t         out_res
);
  import cdt_pkg::*;

  // Date state and the leap flag that trails it, registered through lp_year and lp_cent, then loop_leap.
  logic [YEAR_W-1:0]  cur_year, cur_year_next;
  logic [MONTH_W-1:0] cur_month, cur_month_next;
  logic [DAY_W-1:0]   cur_day, cur_day_next;
  logic [YEAR_W-1:0]  lp_year;
  logic [CENT_W-1:0]  lp_cent;
  logic               loop_leap;

  logic [DAY_W:0]     day_inc, day_sum;
  logic [DAY_W-1:0]   len;
  logic               pop;

  logic b0_v, b1_v, b2_v, out_v;
  logic b0_rdy, b1_rdy, b2_rdy, out_rdy;

  logic [YEAR_W-1:0]  b0_year, b1_year;
  logic [MONTH_W-1:0] b0_month, b1_month, b2_month;
  logic [DAY_W-1:0]   b0_day, b1_day, b2_day;
  time_item_t         b0_item, b1_item, b2_item;
  logic [CENT_W-1:0]  b1_cent;
  logic [SEC_W-1:0]   b1_second, b2_second;
  logic [YEAR_W-1:0]  b2_year;
  logic               b2_leap;
  logic [SUM_W-1:0]   b2_sum;
  result_t            res;

  logic [SOH_W-1:0]  sec_full;
  logic              b1_leap;
  logic [SUM_W-1:0]  year_term, wd_sum;

  assign out_rdy  = !out_v || out_ready;
  assign b2_rdy   = !b2_v || out_rdy;
  assign b1_rdy   = !b1_v || b2_rdy;
  assign b0_rdy   = !b0_v || b1_rdy;
  assign in_ready = b0_rdy;
  assign pop      = in_valid && b0_rdy;

  // A January reached by rollover cannot become February within two items,
  // so the trailing leap flag is always current when the month length needs it.
  always_comb begin
    day_inc        = {1'b0, cur_day} + (DAY_W+1)'(in_item.passed);
    len            = month_length(cur_month, loop_leap);
    day_sum        = day_inc;
    cur_year_next  = cur_year;
    cur_month_next = cur_month;
    if ((cur_month inside {[MONTH_JAN:MONTH_DEC]}) && (day_inc > {1'b0, len})) begin
      day_sum = day_inc - {1'b0, len};
      if (cur_month == MONTH_DEC) begin
        cur_month_next = MONTH_JAN;
        cur_year_next  = (cur_year >= YEAR_LAST) ? YEAR_FIRST : cur_year + 1'b1;
      end else begin
        cur_month_next = cur_month + 1'b1;
      end
    end
    cur_day_next = day_sum[DAY_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_year  <= RESET_YEAR;
      cur_month <= RESET_MONTH;
      cur_day   <= RESET_DAY;
    end else if (cfg.en) begin
      case (cfg.index)
        REG_START_YEAR:  cur_year  <= cfg.data[YEAR_W-1:0];
        REG_START_MONTH: cur_month <= cfg.data[MONTH_W-1:0];
        REG_START_DAY:   cur_day   <= cfg.data[DAY_W-1:0];
        default: ;
      endcase
    end else if (pop) begin
      cur_year  <= cur_year_next;
      cur_month <= cur_month_next;
      cur_day   <= cur_day_next;
    end
  end

  always_ff @(posedge clk) begin
    lp_year   <= cur_year;
    lp_cent   <= div100(cur_year);
    loop_leap <= leap_of(lp_year, lp_cent);
  end

  always_comb begin
    sec_full  = b0_item.soh - SOH_W'(b0_item.minute) * 12'd60;
    b1_leap   = leap_of(b1_year, b1_cent);
    year_term = SUM_W'(b1_year) + SUM_W'(b1_year >> 2) + SUM_W'(b1_cent >> 2)
              - SUM_W'(b1_cent);
    wd_sum    = year_term + SUM_W'(month_offset(b1_month, b1_leap))
              + SUM_W'(b1_day) + 15'd6;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b0_v  <= 1'b0;
      b1_v  <= 1'b0;
      b2_v  <= 1'b0;
      out_v <= 1'b0;
    end else begin
      if (b0_rdy)  b0_v  <= in_valid;
      if (b1_rdy)  b1_v  <= b0_v;
      if (b2_rdy)  b2_v  <= b1_v;
      if (out_rdy) out_v <= b2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (b0_rdy) begin
      b0_year  <= cur_year_next;
      b0_month <= cur_month_next;
      b0_day   <= cur_day_next;
      b0_item  <= in_item;
    end
    if (b1_rdy) begin
      b1_year   <= b0_year;
      b1_month  <= b0_month;
      b1_day    <= b0_day;
      b1_item   <= b0_item;
      b1_cent   <= div100(b0_year);
      b1_second <= sec_full[SEC_W-1:0];
    end
    if (b2_rdy) begin
      b2_year   <= b1_year;
      b2_month  <= b1_month;
      b2_day    <= b1_day;
      b2_item   <= b1_item;
      b2_second <= b1_second;
      b2_leap   <= b1_leap;
      b2_sum    <= wd_sum;
    end
    if (out_rdy) begin
      res.year_now        <= b2_year;
      res.month_now       <= b2_month;
      res.day_now         <= b2_day;
      res.weekday_now     <= mod7(b2_sum);
      res.leap_now        <= b2_leap;
      res.hour_now        <= b2_item.hour;
      res.minute_now      <= b2_item.minute;
      res.second_now      <= b2_second;
      res.restart_counter <= b2_item.passed;
      res.restart_value   <= b2_item.passed ? b2_item.rem : '0;
    end
  end

  assign out_valid = out_v;
  assign out_res   = res;

endmodule

`default_nettype wire

### rtl/core/calendar_date_tracker.sv
`timescale 1ns / 1ps
`default_nettype none

// Takes one seconds reading per beat and returns one beat with the time of day, the kept
// date, its weekday and leap flag, and a restart request with the day remainder. A reading
// is taken every cycle at full rate while the output is not stalled, and its result passes
// through the front stages, a short queue and the back stages. The rate is one beat a cycle
// because the date advance is a single update of the date registers; the time split and
// weekday arithmetic run in pipeline stages on either side of the queue. Configuration
// writes load the date at once and must only be made while no beat is in flight.
module calendar_date_tracker #(
  parameter int unsigned QUEUE_DEPTH = cdt_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [23:0]                   s_tdata,   // seconds_count
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // year_now, month_now, day_now, weekday_now, leap_now, hour_now, minute_now,
  // second_now, restart_counter, restart_value
  output logic [63:0]                        m_tdata,
  input  wire logic                          cfg_wr_en,
  input  wire logic [cdt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cdt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cdt_pkg::*;

  logic       fq_valid, fq_ready, qb_valid, qb_ready;
  time_item_t fq_item, qb_item;
  cfg_wr_t    cfg;
  result_t    res;

  assign cfg.en    = cfg_wr_en;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  cdt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_count  (s_tdata[COUNT_W-1:0]),
    .out_valid (fq_valid),
    .out_ready (fq_ready),
    .out_item  (fq_item)
  );

  cdt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_item  (fq_item),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_item   (qb_item)
  );

  cdt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (qb_valid),
    .in_ready  (qb_ready),
    .in_item   (qb_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  assign m_tdata = {2'b00, res};

endmodule

`default_nettype wire

### rtl/core/cdt_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module cdt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [63:0] m_tdata
);

  // No beat may be offered straight after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result offered right after reset");

  // Weekday and time of day stay within their ranges.
  a_ranges: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[25:23] != 3'd7) && (m_tdata[31:27] < 5'd24)
                 && (m_tdata[37:32] < 6'd60) && (m_tdata[43:38] < 6'd60))
    else $error("weekday or time of day out of range");

  // Without a restart request the restart value is zero.
  a_restart_value: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[44]) |-> (m_tdata[61:45] == 17'd0))
    else $error("restart value set without a restart request");

  // A leap year is always a multiple of four.
  a_leap_year: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[26]) |-> (m_tdata[1:0] == 2'd0))
    else $error("leap flag on a year not divisible by four");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result beat changed");

endmodule

bind calendar_date_tracker cdt_checker u_cdt_checker (.*);

`default_nettype wire

### dv/cdt_date_sb_pkg.sv
`timescale 1ns / 1ps

package cdt_date_sb_pkg;

  import cdt_pkg::*;

  localparam int unsigned DAY_SECS  = 86400;
  localparam int unsigned HOUR_SECS = 3600;
  localparam int unsigned MIN_SECS  = 60;

  localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int unsigned WDAY_SHIFT_COMMON [12] = '{0, 3, 3, 6, 1, 4, 6, 2, 5, 0, 3, 5};
  localparam int unsigned WDAY_SHIFT_LEAP   [12] = '{6, 2, 3, 6, 1, 4, 6, 2, 5, 0, 3, 5};

  class date_scoreboard;

    logic [YEAR_W-1:0]  cur_year;
    logic [MONTH_W-1:0] cur_month;
    logic [DAY_W-1:0]   cur_day;
    result_t            expected_dates [$];
    int unsigned        errors;

    function new();
      cur_year  = RESET_YEAR;
      cur_month = RESET_MONTH;
      cur_day   = RESET_DAY;
      errors    = 0;
    endfunction

    function automatic bit leap_year(input int unsigned y);
      return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    function void load_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_START_YEAR:  cur_year  = v[YEAR_W-1:0];
        REG_START_MONTH: cur_month = v[MONTH_W-1:0];
        REG_START_DAY:   cur_day   = v[DAY_W-1:0];
        default: ;
      endcase
    endfunction

    // Advances the kept date for one accepted reading and queues the beat it should give.
    function void note_count(input logic [COUNT_W-1:0] cnt);
      int unsigned c, rest, d, len, y, ysum, shift;
      bit          passed, lp;
      result_t     r;
      c      = cnt;
      rest   = c % DAY_SECS;
      passed = c >= DAY_SECS;
      d      = cur_day + (passed ? 1 : 0);
      if (cur_month >= MONTH_JAN && cur_month <= MONTH_DEC) begin
        len = MONTH_DAYS[cur_month - 1];
        if (cur_month == MONTH_FEB && leap_year(cur_year)) len = 29;
        // A day past the month end folds into the next month once, whether it came
        // from the advance or straight from a register write.
        if (d > len) begin
          d = d - len;
          if (cur_month == MONTH_DEC) begin
            cur_month = MONTH_JAN;
            cur_year  = (cur_year >= YEAR_LAST) ? YEAR_FIRST : cur_year + 1'b1;
          end else begin
            cur_month = cur_month + 1'b1;
          end
        end
      end
      cur_day = d[DAY_W-1:0];

      y     = cur_year;
      lp    = leap_year(y);
      ysum  = y + y / 4 + y / 400 - y / 100;
      shift = 0;
      if (cur_month >= MONTH_JAN && cur_month <= MONTH_DEC)
        shift = lp ? WDAY_SHIFT_LEAP[cur_month - 1] : WDAY_SHIFT_COMMON[cur_month - 1];

      r.year_now        = cur_year;
      r.month_now       = cur_month;
      r.day_now         = cur_day;
      r.weekday_now     = WDAY_W'((ysum + shift + cur_day + 6) % 7);
      r.leap_now        = lp;
      r.hour_now        = HOUR_W'(rest / HOUR_SECS);
      r.minute_now      = MIN_W'((rest % HOUR_SECS) / MIN_SECS);
      r.second_now      = SEC_W'(rest % MIN_SECS);
      r.restart_counter = passed;
      r.restart_value   = passed ? REM_W'(rest) : '0;
      expected_dates.push_back(r);
    endfunction

    function void compare_field(input string name, input int unsigned exp_v,
                                input int unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(input result_t got);
      result_t exp_r;
      if (expected_dates.size() == 0) begin
        $error("result beat with no reading outstanding");
        errors++;
        return;
      end
      exp_r = expected_dates.pop_front();
      compare_field("year_now", exp_r.year_now, got.year_now);
      compare_field("month_now", exp_r.month_now, got.month_now);
      compare_field("day_now", exp_r.day_now, got.day_now);
      compare_field("weekday_now", exp_r.weekday_now, got.weekday_now);
      compare_field("leap_now", exp_r.leap_now, got.leap_now);
      compare_field("hour_now", exp_r.hour_now, got.hour_now);
      compare_field("minute_now", exp_r.minute_now, got.minute_now);
      compare_field("second_now", exp_r.second_now, got.second_now);
      compare_field("restart_counter", exp_r.restart_counter, got.restart_counter);
      compare_field("restart_value", exp_r.restart_value, got.restart_value);
    endfunction

    function int unsigned pending();
      return expected_dates.size();
    endfunction

  endclass

endpackage

### dv/tb.sv
`timescale 1ns / 1ps

module tb;

  import cdt_pkg::*;
  import cdt_date_sb_pkg::*;

  localparam int unsigned NUM_PHASES   = 12;
  localparam int unsigned PHASE_ITEMS  = 165;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned IDLE_LIMIT   = 4000;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [23:0]           s_tdata = '0;    // seconds_count
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // year_now, month_now, day_now, weekday_now, leap_now, hour_now, minute_now,
  // second_now, restart_counter, restart_value
  logic [63:0]           m_tdata;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  date_scoreboard dates = new();

  bit          tx_steady;
  bit          rx_steady;
  bit          hold_req;
  int unsigned idle_cycles;

  calendar_date_tracker dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: a random stall before each beat unless rx_steady is set, or one long hold-off on request.
  initial begin
    int unsigned stall;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      stall = rx_steady ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      dates.check_result(result_t'(m_tdata[61:0]));
    end
  end

  task automatic send_count(input logic [COUNT_W-1:0] cnt, input bit no_gap);
    int unsigned gap;
    gap = (no_gap || tx_steady) ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= 24'(cnt);
    do @(posedge clk); while (!s_tready);
    dates.note_count(cnt);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (dates.pending() != 0) @(posedge clk);
    // Let the last beat clear the pipeline before anything is written.
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    dates.load_reg(idx, v);
  endtask

  task automatic set_date(input int unsigned y, input int unsigned m, input int unsigned d);
    drain();
    write_reg(REG_START_YEAR, CFG_DATA_W'(y));
    write_reg(REG_START_MONTH, CFG_DATA_W'(m));
    write_reg(REG_START_DAY, CFG_DATA_W'(d));
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [COUNT_W-1:0] random_count();
    logic [COUNT_W-1:0] c;
    case ($urandom_range(0, 19))
      0: c = '0;
      1: c = COUNT_W'(DAY_SECS - 1);
      2: c = COUNT_W'(DAY_SECS);
      3: c = COUNT_W'(2 * DAY_SECS - 1);
      4, 5, 6, 7, 8, 9, 10, 11: c = COUNT_W'($urandom_range(DAY_SECS, 2 * DAY_SECS - 1));
      default: c = COUNT_W'($urandom_range(0, DAY_SECS - 1));
    endcase
    return c;
  endfunction

  initial begin
    int unsigned y, m, d, len;
    int unsigned century_years [7];
    century_years = '{1600, 1896, 1900, 2000, 2096, 2100, 2400};
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    hold_req  = 1'b0;
    idle_cycles = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset date, count extremes and every count bit.
    send_count('0, 1'b0);
    send_count(COUNT_W'(DAY_SECS - 1), 1'b0);
    send_count(COUNT_W'(DAY_SECS), 1'b0);
    send_count(COUNT_W'(2 * DAY_SECS - 1), 1'b0);
    send_count(18'h1FFFF, 1'b0);
    send_count(18'h20000, 1'b0);
    // Century leap year and a century common year across the end of February.
    set_date(2000, MONTH_FEB, 28);
    send_count(COUNT_W'(DAY_SECS), 1'b0);
    send_count(COUNT_W'(DAY_SECS), 1'b0);
    set_date(1900, MONTH_FEB, 28);
    send_count(COUNT_W'(DAY_SECS), 1'b0);
    // Rollover out of the last December, also from a year above the last one.
    set_date(YEAR_LAST, MONTH_DEC, 31);
    send_count(18'd100000, 1'b0);
    set_date(16383, MONTH_DEC, 31);
    send_count(COUNT_W'(DAY_SECS), 1'b0);
    // Month out of range: the day wraps within five bits and no month rolls.
    set_date(0, 0, 31);
    send_count(COUNT_W'(DAY_SECS), 1'b0);
    send_count('0, 1'b0);
    set_date(2022, 13, 5);
    send_count(18'd3599, 1'b0);
    // A day above the month length folds on the next reading.
    set_date(2023, MONTH_APR, 31);
    send_count('0, 1'b0);
    set_date(2024, MONTH_FEB, 31);
    send_count(COUNT_W'(DAY_SECS), 1'b0);
    set_date(2021, 15, 0);
    send_count(18'd3600, 1'b0);

    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      case ($urandom_range(0, 5))
        0, 1: y = $urandom_range(1, 9999);
        2: y = century_years[$urandom_range(0, 6)];
        3: y = $urandom_range(9998, 9999);
        4: y = $urandom_range(2019, 2025);
        default: y = $urandom_range(0, 16383);
      endcase
      m = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 0 : $urandom_range(13, 15))
                                      : $urandom_range(1, 12);
      len = (m >= 1 && m <= 12) ? MONTH_DAYS[m - 1] : 31;
      case ($urandom_range(0, 7))
        0: d = $urandom_range(0, 31);
        1, 2: d = $urandom_range(1, len);
        default: d = $urandom_range(len - 3, len);
      endcase
      set_date(y, m, d);

      tx_steady = (p % 4 == 1);
      rx_steady = (p % 3 == 2);
      if (p == 2) hold_req = 1'b1;
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
        // While the result side holds off, offer readings back to back so the block fills.
        send_count(random_count(), (p == 2) && (i < 60));
        if (p == 5 && i == PHASE_ITEMS / 2) begin
          s_tvalid <= 1'b0;
          while (dates.pending() != 0) @(posedge clk);
        end
      end
    end

    drain();
    if (dates.errors == 0 && dates.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/cdt_pkg.sv
rtl/core/cdt_front.sv
rtl/core/cdt_queue.sv
rtl/core/cdt_back.sv
rtl/core/calendar_date_tracker.sv
rtl/core/cdt_checker.sv
dv/cdt_date_sb_pkg.sv
dv/tb.sv
